/* rtl/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`default_nettype none

package u8u16_pkg;

   // Default depth of the result queue; two slots are the minimum.
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic [15:0] unit;
      logic        replaced;
      logic        last;
   } result_type;

   // Results one byte produces: count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_out_type;

endpackage

`default_nettype wire

/* rtl/u8u16_step.sv */
// Per-byte decode step with the sequence state registers.
`default_nettype none

module u8u16_step (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire logic [7:0]              in_byte,
   output u8u16_pkg::step_out_type      step_out
);

   localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
   localparam logic [7:0]  LEAD_MIN     = 8'hC2;
   localparam logic [7:0]  LEAD3_MIN    = 8'hE0;
   localparam logic [7:0]  LEAD4_MIN    = 8'hF0;
   localparam logic [7:0]  LEAD_LIMIT   = 8'hF5;
   localparam logic [7:0]  CONT_MASK    = 8'hC0;
   localparam logic [7:0]  CONT_TAG     = 8'h80;
   localparam logic [20:0] BMP_LIMIT    = 21'h10000;

   typedef struct packed {
      logic                   emit;
      u8u16_pkg::result_type  res;
      logic [1:0]             pend;
      logic [20:0]            accum;
   } lead_type;

   logic [1:0]  pend_ff,  pend_in;
   logic [20:0] accum_ff, accum_in;
   logic [20:0] acc_shift;
   logic [1:0]  pend_dec;
   lead_type    lead;

   function automatic u8u16_pkg::result_type code_res(input logic [20:0] c);
      u8u16_pkg::result_type r;
      r.last = 1'b1;
      if (c < BMP_LIMIT) begin
         r.unit     = c[15:0];
         r.replaced = 1'b0;
      end else begin
         r.unit     = REPL_CHAR;
         r.replaced = 1'b1;
      end
      return r;
   endfunction

   // Byte seen with no sequence open.
   function automatic lead_type take_lead(input logic [7:0] b);
      lead_type r;
      r.emit         = 1'b1;
      r.res.unit     = {8'h00, b};
      r.res.replaced = 1'b0;
      r.res.last     = 1'b1;
      r.pend         = 2'd0;
      r.accum        = '0;
      if (b[7]) begin
         if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
            r.res.unit     = REPL_CHAR;
            r.res.replaced = 1'b1;
         end else begin
            r.emit = 1'b0;
            if (b < LEAD3_MIN) begin
               r.pend  = 2'd1;
               r.accum = {16'd0, b[4:0]};
            end else if (b < LEAD4_MIN) begin
               r.pend  = 2'd2;
               r.accum = {17'd0, b[3:0]};
            end else begin
               r.pend  = 2'd3;
               r.accum = {18'd0, b[2:0]};
            end
         end
      end
      return r;
   endfunction

   assign lead      = take_lead(in_byte);
   // six payload bits shift in; the top bits fall off at 21
   assign acc_shift = {accum_ff[14:0], in_byte[5:0]};
   assign pend_dec  = pend_ff - 2'd1;

   always_comb begin
      pend_in                  = pend_ff;
      accum_in                 = accum_ff;
      step_out                 = '0;
      step_out.first.last      = 1'b1;
      step_out.second.last     = 1'b1;
      if (pend_ff == 2'd0) begin
         pend_in        = lead.pend;
         accum_in       = lead.accum;
         step_out.first = lead.res;
         step_out.count = lead.emit ? 2'd1 : 2'd0;
      end else if (in_byte == 8'h00) begin
         // zero ends the character early; the partial code goes out
         pend_in        = 2'd0;
         accum_in       = '0;
         step_out.first = code_res(accum_ff);
         step_out.count = 2'd1;
      end else if ((in_byte & CONT_MASK) == CONT_TAG) begin
         pend_in = pend_dec;
         if (pend_dec == 2'd0) begin
            accum_in       = '0;
            step_out.first = code_res(acc_shift);
            step_out.count = 2'd1;
         end else begin
            accum_in = acc_shift;
         end
      end else begin
         // broken sequence: replacement, then the byte again as a lead
         pend_in                 = lead.pend;
         accum_in                = lead.accum;
         step_out.first.unit     = REPL_CHAR;
         step_out.first.replaced = 1'b1;
         step_out.first.last     = !lead.emit;
         step_out.second         = lead.res;
         step_out.count          = lead.emit ? 2'd2 : 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 2'd0;
         accum_ff <= '0;
      end else if (adv) begin
         pend_ff  <= pend_in;
         accum_ff <= accum_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/u8u16_rsp_fifo.sv */
// Result queue: takes up to two results a cycle, hands out one.
`default_nettype none

module u8u16_rsp_fifo #(
   parameter int DEPTH = u8u16_pkg::RSP_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [1:0]             push_count,
   input  wire u8u16_pkg::result_type  push_first,
   input  wire u8u16_pkg::result_type  push_second,
   output logic                        room,
   input  wire logic                   pop,
   output logic                        head_valid,
   output u8u16_pkg::result_type       head
);

   localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
   localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

   u8u16_pkg::result_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_next;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + PW'(1);
   endfunction

   assign wr_ptr_next = inc(wr_ptr_ff);
   assign room        = count_ff <= ROOM_MAX;
   assign head_valid  = count_ff != '0;
   assign head        = mem_ff[rd_ptr_ff];

   always_comb begin
      case (push_count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = inc(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push_second;
      end
   end

endmodule

`default_nettype wire

/* rtl/utf8_to_utf16_bmp_decoder.sv */
// Top level: UTF-8 byte stream in, UTF-16 BMP code units out.
//
// req channel: one UTF-8 byte per item (req_in_byte), valid/stall.
// rsp channel: one code unit per item with replaced and last_of_run flags.
// A byte yields zero, one or two result items; last_of_run marks the final
// item that a byte produced (the first of a pair carries 0).
// A byte is taken into the input register, decoded from there, and its
// results are written into the result queue, whose head drives rsp.
// Throughput: one byte per cycle while the result queue has two free
// slots. The result queue drains one item per cycle when the receiver
// does not stall; the input register moves on whenever the queue has two
// free slots.
// req_stall rises when the input register holds a byte and the result
// queue has fewer than two free slots; it never depends on req_valid.
// When the receiver stalls, the head item holds on the rsp ports and the
// queue fills, then the input side stalls in turn; nothing is dropped.
// Reset (synchronous) empties the input register and the queue and
// closes any open sequence.
`default_nettype none

module utf8_to_utf16_bmp_decoder #(
   parameter int RSP_DEPTH = u8u16_pkg::RSP_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_utf16_unit,
   output logic             rsp_replaced,
   output logic             rsp_last_of_run
);

   logic                    in_vld_ff, in_vld_in;
   logic [7:0]              in_byte_ff;
   logic                    load;
   logic                    adv;
   logic                    room;
   logic                    pop;
   logic [1:0]              push_count;
   u8u16_pkg::step_out_type step_out;
   u8u16_pkg::result_type   head;

   // input register advances only when its results are sure to fit
   assign adv        = in_vld_ff && room;
   assign req_stall  = in_vld_ff && !room;
   assign load       = req_valid && !req_stall;
   assign in_vld_in  = load ? 1'b1 : (adv ? 1'b0 : in_vld_ff);
   assign push_count = adv ? step_out.count : 2'd0;
   assign pop        = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff <= req_in_byte;
      end
   end

   u8u16_step u_step (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_byte  (in_byte_ff),
      .step_out (step_out)
   );

   u8u16_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (step_out.first),
      .push_second (step_out.second),
      .room        (room),
      .pop         (pop),
      .head_valid  (rsp_valid),
      .head        (head)
   );

   assign rsp_utf16_unit  = head.unit;
   assign rsp_replaced    = head.replaced;
   assign rsp_last_of_run = head.last;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the UTF-8 to UTF-16 BMP decoder.
`timescale 1ns / 100ps

module tb_top;

   localparam int          CLK_HALF     = 4;        // 8 ns period
   localparam int          RESET_CYCLES = 6;
   localparam int          QUIET_LIMIT  = 1000;     // cycles with no handshake at all
   localparam int          TAIL_CYCLES  = 10;       // settle time after the final drain
   localparam int          HOLD_CYCLES  = 80;       // long receiver hold-off
   localparam logic [15:0] REPL_UNIT    = 16'hfffd;
   localparam logic [20:0] BMP_LIMIT    = 21'h10000;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte     = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [15:0] rsp_utf16_unit;
   logic        rsp_replaced;
   logic        rsp_last_of_run;

   // Idle rates in percent, set per phase by the tests.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Long hold-off request: the test bumps hold_req_cnt, the receiver
   // process notices the change and counts the stretch down itself.
   int hold_req_cnt = 0;
   int hold_taken   = 0;
   int hold_left    = 0;

   // Decoder model state and the code units it still expects to see.
   logic [1:0]  pend_conts = 2'd0;
   logic [20:0] code_acc   = 21'd0;
   u8u16_pkg::result_type expected_units [$];

   // Run statistics.
   int bytes_sent    = 0;
   int units_checked = 0;
   int repl_seen     = 0;
   int pairs_seen    = 0;
   int mismatch_cnt  = 0;

   utf8_to_utf16_bmp_decoder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_utf16_unit  (rsp_utf16_unit),
      .rsp_replaced    (rsp_replaced),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #CLK_HALF clock = ~clock;

   // ------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------
   function automatic void push_unit(logic [15:0] u, logic r, logic l);
      expected_units.push_back('{unit: u, replaced: r, last: l});
   endfunction

   // Finished character: anything outside the BMP turns into U+FFFD.
   function automatic void push_code(logic [20:0] c);
      if (c < BMP_LIMIT)
         push_unit(c[15:0], 1'b0, 1'b1);
      else
         push_unit(REPL_UNIT, 1'b1, 1'b1);
   endfunction

   // Byte seen with no sequence open.
   function automatic void decode_lead(logic [7:0] b);
      if (b < 8'h80) begin
         push_unit({8'h00, b}, 1'b0, 1'b1);
      end else if (b < 8'hc2 || b >= 8'hf5) begin
         push_unit(REPL_UNIT, 1'b1, 1'b1);
      end else if (b < 8'he0) begin
         pend_conts = 2'd1;
         code_acc   = {16'd0, b[4:0]};
      end else if (b < 8'hf0) begin
         pend_conts = 2'd2;
         code_acc   = {17'd0, b[3:0]};
      end else begin
         pend_conts = 2'd3;
         code_acc   = {18'd0, b[2:0]};
      end
   endfunction

   function automatic void predict_decode(logic [7:0] b);
      logic lead_emits;
      // As a lead, only C2..F4 open a sequence silently; all else emits.
      lead_emits = (b < 8'hc2) || (b >= 8'hf5);
      if (pend_conts == 2'd0) begin
         decode_lead(b);
      end else if (b == 8'h00) begin
         // zero inside a sequence flushes the partial code, no unit of its own
         pend_conts = 2'd0;
         push_code(code_acc);
         code_acc = 21'd0;
      end else if (b[7:6] == 2'b10) begin
         code_acc   = {code_acc[14:0], b[5:0]};
         pend_conts = pend_conts - 2'd1;
         if (pend_conts == 2'd0) begin
            push_code(code_acc);
            code_acc = 21'd0;
         end
      end else begin
         // broken sequence: replace, then reuse the byte as a lead;
         // the replacement is not last if the lead emits too
         pend_conts = 2'd0;
         code_acc   = 21'd0;
         push_unit(REPL_UNIT, 1'b1, !lead_emits);
         decode_lead(b);
      end
   endfunction

   // ------------------------------------------------------------------
   // Sender: drives at the falling edge, sees acceptance at the rising one
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid   <= 1'b0;
         req_in_byte <= 8'($urandom);
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      // payload stays put until the decoder takes it
      do @(posedge clock); while (req_stall);
      predict_decode(b);
      bytes_sent++;
   endtask

   // Drop valid, then wait until every expected unit has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
   endtask

   // One character-sized group: mostly well-formed sequences with random
   // payload bits, some truncated ones, some raw noise.
   task automatic send_random_group();
      int         kind;
      int         conts;
      int         keep;
      logic [7:0] lead;
      logic [7:0] tail;
      kind = $urandom_range(99);
      if (kind < 25) begin
         send_byte(8'($urandom_range(8'h7f)));
      end else if (kind < 85) begin
         if (kind < 45) begin
            lead  = 8'($urandom_range(8'hdf, 8'hc2));
            conts = 1;
         end else if (kind < 65) begin
            lead  = 8'($urandom_range(8'hef, 8'he0));
            conts = 2;
         end else begin
            lead  = 8'($urandom_range(8'hf4, 8'hf0));
            conts = 3;
         end
         keep = conts;
         if (kind % 4 == 0) keep = $urandom_range(conts - 1, 0);
         send_byte(lead);
         for (int i = 0; i < keep; i++) send_byte({2'b10, 6'($urandom)});
         if (keep < conts) begin
            // cut the sequence short with a zero or a non-continuation
            tail = 8'($urandom);
            if (tail[7:6] == 2'b10) tail[6] = 1'b1;
            if ($urandom_range(3) == 0) tail = 8'h00;
            send_byte(tail);
         end
      end else begin
         send_byte(8'($urandom));
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall, plus the long hold-off when requested
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_req_cnt != hold_taken) begin
         hold_taken = hold_req_cnt;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Checker: every accepted unit against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_units
      u8u16_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         units_checked++;
         if (rsp_replaced) repl_seen++;
         if (!rsp_last_of_run) pairs_seen++;
         if (expected_units.size() == 0) begin
            $error("unexpected unit: utf16_unit %h replaced %b last_of_run %b",
                   rsp_utf16_unit, rsp_replaced, rsp_last_of_run);
            mismatch_cnt++;
         end else begin
            want = expected_units.pop_front();
            if (rsp_utf16_unit !== want.unit) begin
               $error("utf16_unit: expected %h, got %h", want.unit, rsp_utf16_unit);
               mismatch_cnt++;
            end
            if (rsp_replaced !== want.replaced) begin
               $error("replaced: expected %b, got %b", want.replaced, rsp_replaced);
               mismatch_cnt++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %b, got %b", want.last, rsp_last_of_run);
               mismatch_cnt++;
            end
         end
      end
   end

   // Watchdog: too long without any handshake on either side ends the run.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("utf8_to_utf16_bmp_decoder verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_reset();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   endtask

   // Field extremes and every special case, no idling.
   task automatic test_directed();
      logic [7:0] seq [];
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      seq = '{8'h00, 8'h7f,                     // ASCII extremes
              8'h80, 8'hc1, 8'hf5, 8'hff,       // invalid leads
              8'hc2, 8'h80,                     // smallest two-byte
              8'hef, 8'hbf, 8'hbf,              // U+FFFF
              8'hf0, 8'h90, 8'h80, 8'h80,       // U+10000, out of range
              8'hc3, 8'h41,                     // broken, then ASCII: two units
              8'he2, 8'h82, 8'hc3, 8'ha9,       // broken by a new lead: one unit
              8'hc2, 8'hff,                     // broken, then invalid lead: two units
              8'hc5, 8'h00};                    // zero flushes the partial code
      foreach (seq[i]) send_byte(seq[i]);
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering: the result queue
   // fills and the input side has to stall.
   task automatic test_hold_off();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_req_cnt++;
      repeat (30) send_random_group();
      wait_drained();
   endtask

   task automatic test_random_phase(input int n_bytes, input int send_pct,
                                    input int stall_pct);
      int target;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) send_random_group();
      // sender pauses until all outstanding units are back
      wait_drained();
   endtask

   initial begin
      test_reset();
      test_directed();
      test_hold_off();
      test_random_phase(200, 0, 0);
      test_random_phase(200, 73, 0);
      test_random_phase(200, 0, 73);
      test_random_phase(200, 29, 29);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Summary: %0d UTF-8 bytes decoded into %0d checked units", bytes_sent,
               units_checked);
      $display("  %0d replacement units, %0d bytes that gave two units", repl_seen,
               pairs_seen);
      if (mismatch_cnt == 0 && expected_units.size() == 0)
         $display("utf8_to_utf16_bmp_decoder verification clean");
      else
         $display("utf8_to_utf16_bmp_decoder verification failed");
      $finish;
   end

endmodule

/* utf8_to_utf16_bmp_decoder.f */
rtl/u8u16_pkg.sv
rtl/u8u16_step.sv
rtl/u8u16_rsp_fifo.sv
rtl/utf8_to_utf16_bmp_decoder.sv
sim/tb_top.sv
